/* rtl/pdlz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared types and constants of the PalmDOC LZ77 decompressor.
// ----------------------------------------------------------------------------
package pdlz_pkg;

    // History window and output counting.
    localparam int WINDOW_DEPTH = 2048;
    localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
    localparam int MAX_OUT      = 4096;
    localparam int CNT_W        = 13;
    localparam int DIST_W       = 11;

    // Byte classes and token constants.
    localparam logic [7:0] TOK_SPACE_PAIR = 8'hC0;
    localparam logic [7:0] TOK_PAIR       = 8'h80;
    localparam logic [7:0] TOK_PLAIN      = 8'h09;
    localparam logic [7:0] TOK_ZERO       = 8'h00;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] XOR_MASK       = 8'h80;
    localparam logic [3:0] LEN_BIAS       = 4'd3;

    // Limit on produced bytes as a count-width constant.
    localparam logic [CNT_W-1:0] MAX_OUT_CNT = CNT_W'(MAX_OUT);

    // Record status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_BAD_DIST = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Decoder phase between input bytes.
    typedef enum logic [1:0] {
        PH_TOKEN = 2'd0,
        PH_PAIR  = 2'd1,
        PH_LIT   = 2'd2
    } t_phase;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_READ,
        S_COPY,
        S_END
    } t_state;

    // Results of the shared count and address unit.
    typedef struct packed {
        logic              at_limit;
        logic              next_fail;
        logic              dist_bad;
        logic [CNT_W-1:0]  produced_inc;
        logic [HIST_AW-1:0] src_addr;
    } t_emit_info;

endpackage : pdlz_pkg
`default_nettype wire

/* rtl/pdlz_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdlz_if
// Valid/ready channels for compressed input beats and decoded result beats.
// ----------------------------------------------------------------------------
interface pdlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       record_end;

    modport source (output valid, output in_byte, output record_end, input ready);
    modport sink   (input valid, input in_byte, input record_end, output ready);
endinterface : pdlz_in_if

interface pdlz_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        record_done;
    logic [1:0]  status;
    logic [12:0] out_length;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output record_done, output status, output out_length, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input record_done, input status, input out_length, output ready);
endinterface : pdlz_out_if
`default_nettype wire

/* rtl/palmdoc_lz77_decompressor_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top
// PalmDOC LZ77 record decoder with a 2048-byte history window.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_in      sink       in_byte[7:0], record_end
//  o_out     source     out_byte[7:0], byte_valid, run_last, record_done,
//                       status[1:0], out_length[12:0]
//  i_cfg_*   write      out_capacity[12:0]
//
// An input beat is accepted in the idle state; each literal or space byte is
// then emitted, each back-reference byte needs a history read, then an emit,
// and record end adds a status beat; no new beat is taken until idle again.
// The single history read port sets the back-reference rate.
// Reset is synchronous and active low; it restores the capacity to 4096 and
// the decoder to its token phase. The history needs no clearing.
// A stalled output holds the sequencer in its emit, copy or end state.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pdlz_in_if.sink          i_in,
    pdlz_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_data
);
    import pdlz_pkg::*;

    // Control state.
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    t_status            r_err, n_err;
    logic [5:0]         r_pair_hi, n_pair_hi;
    logic [3:0]         r_lits, n_lits;
    logic [CNT_W-1:0]   r_produced, n_produced;
    logic [CNT_W-1:0]   r_cap;
    logic               r_end, n_end;
    logic               r_second, n_second;
    logic [7:0]         r_emit_byte, n_emit_byte;
    logic [7:0]         r_second_byte, n_second_byte;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [3:0]         r_copy_left, n_copy_left;

    // Output register.
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_obvalid, n_obvalid;
    logic               r_olast, n_olast;
    logic               r_odone, n_odone;
    t_status            r_ostatus, n_ostatus;
    logic [CNT_W-1:0]   r_olen, n_olen;

    // History and shared unit connections.
    logic               hist_we;
    logic [7:0]         hist_wdata;
    logic               hist_re;
    logic [7:0]         hist_rdata;
    logic [DIST_W-1:0]  u_dist;
    t_emit_info         info;
    logic               slot_free;
    logic [7:0]         b;

    assign b         = i_in.in_byte;
    assign slot_free = !r_ovalid || o_out.ready;
    assign u_dist    = (r_state == S_IDLE) ? {r_pair_hi, b[7:3]} : r_dist;

    pdlz_emit_unit u_emit (
        .i_produced (r_produced),
        .i_capacity (r_cap),
        .i_dist     (u_dist),
        .o_info     (info)
    );

    pdlz_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_produced[HIST_AW-1:0]),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (info.src_addr),
        .o_rdata (hist_rdata)
    );

    // Sequencer: next state, decoder updates and output loads.
    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_err         = r_err;
        n_pair_hi     = r_pair_hi;
        n_lits        = r_lits;
        n_produced    = r_produced;
        n_end         = r_end;
        n_second      = r_second;
        n_emit_byte   = r_emit_byte;
        n_second_byte = r_second_byte;
        n_dist        = r_dist;
        n_copy_left   = r_copy_left;
        n_ovalid      = r_ovalid && !o_out.ready;
        n_obyte       = r_obyte;
        n_obvalid     = r_obvalid;
        n_olast       = r_olast;
        n_odone       = r_odone;
        n_ostatus     = r_ostatus;
        n_olen        = r_olen;
        hist_we       = 1'b0;
        hist_wdata    = r_emit_byte;
        hist_re       = 1'b0;
        i_in.ready    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_end   = i_in.record_end;
                    n_state = i_in.record_end ? S_END : S_IDLE;
                    if (r_err == ST_OK) begin
                        if (r_phase == PH_LIT) begin
                            // Raw byte of a literal run.
                            n_emit_byte = b;
                            n_second    = 1'b0;
                            n_lits      = r_lits - 4'd1;
                            if (r_lits == 4'd1) begin
                                n_phase = PH_TOKEN;
                            end
                            n_state = S_EMIT;
                        end else if (r_phase == PH_PAIR) begin
                            // Second byte of a back reference.
                            n_phase = PH_TOKEN;
                            if (info.dist_bad) begin
                                n_err = ST_BAD_DIST;
                            end else begin
                                n_dist      = u_dist;
                                n_copy_left = {1'b0, b[2:0]} + LEN_BIAS;
                                n_state     = S_READ;
                            end
                        end else if (b >= TOK_SPACE_PAIR) begin
                            n_emit_byte   = SPACE_BYTE;
                            n_second_byte = b ^ XOR_MASK;
                            n_second      = 1'b1;
                            n_state       = S_EMIT;
                        end else if (b >= TOK_PAIR) begin
                            n_pair_hi = b[5:0];
                            n_phase   = PH_PAIR;
                        end else if (b >= TOK_PLAIN || b == TOK_ZERO) begin
                            n_emit_byte = b;
                            n_second    = 1'b0;
                            n_state     = S_EMIT;
                        end else begin
                            n_lits  = b[3:0];
                            n_phase = PH_LIT;
                        end
                    end
                end
            end

            S_EMIT: begin
                if (info.at_limit) begin
                    n_err   = ST_OVERFLOW;
                    n_state = r_end ? S_END : S_IDLE;
                end else if (slot_free) begin
                    hist_we    = 1'b1;
                    hist_wdata = r_emit_byte;
                    n_produced = info.produced_inc;
                    n_ovalid   = 1'b1;
                    n_obyte    = r_emit_byte;
                    n_obvalid  = 1'b1;
                    n_olast    = !r_end && (!r_second || info.next_fail);
                    n_odone    = 1'b0;
                    n_ostatus  = ST_OK;
                    n_olen     = '0;
                    if (r_second) begin
                        n_emit_byte = r_second_byte;
                        n_second    = 1'b0;
                    end else begin
                        n_state = r_end ? S_END : S_IDLE;
                    end
                end
            end

            S_READ: begin
                hist_re = 1'b1;
                n_state = S_COPY;
            end

            S_COPY: begin
                if (info.at_limit) begin
                    n_err   = ST_OVERFLOW;
                    n_state = r_end ? S_END : S_IDLE;
                end else if (slot_free) begin
                    hist_we     = 1'b1;
                    hist_wdata  = hist_rdata;
                    n_produced  = info.produced_inc;
                    n_copy_left = r_copy_left - 4'd1;
                    n_ovalid    = 1'b1;
                    n_obyte     = hist_rdata;
                    n_obvalid   = 1'b1;
                    n_olast     = !r_end && (r_copy_left == 4'd1 || info.next_fail);
                    n_odone     = 1'b0;
                    n_ostatus   = ST_OK;
                    n_olen      = '0;
                    if (r_copy_left == 4'd1) begin
                        n_state = r_end ? S_END : S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end

            S_END: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = '0;
                    n_obvalid = 1'b0;
                    n_olast   = 1'b1;
                    n_odone   = 1'b1;
                    n_olen    = r_produced;
                    if (r_err != ST_OK) begin
                        n_ostatus = r_err;
                    end else if (r_phase != PH_TOKEN) begin
                        n_ostatus = ST_TRUNC;
                    end else begin
                        n_ostatus = ST_OK;
                    end
                    n_phase    = PH_TOKEN;
                    n_pair_hi  = '0;
                    n_lits     = '0;
                    n_produced = '0;
                    n_err      = ST_OK;
                    n_end      = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decoder control registers and the capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TOKEN;
            r_err      <= ST_OK;
            r_pair_hi  <= '0;
            r_lits     <= '0;
            r_produced <= '0;
            r_end      <= 1'b0;
            r_second   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cap      <= MAX_OUT_CNT;
        end else begin
            r_phase    <= n_phase;
            r_err      <= n_err;
            r_pair_hi  <= n_pair_hi;
            r_lits     <= n_lits;
            r_produced <= n_produced;
            r_end      <= n_end;
            r_second   <= n_second;
            r_ovalid   <= n_ovalid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_emit_byte   <= n_emit_byte;
        r_second_byte <= n_second_byte;
        r_dist        <= n_dist;
        r_copy_left   <= n_copy_left;
        r_obyte       <= n_obyte;
        r_obvalid     <= n_obvalid;
        r_olast       <= n_olast;
        r_odone       <= n_odone;
        r_ostatus     <= n_ostatus;
        r_olen        <= n_olen;
    end

    // Result beat outputs.
    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.byte_valid  = r_obvalid;
    assign o_out.run_last    = r_olast;
    assign o_out.record_done = r_odone;
    assign o_out.status      = r_ostatus;
    assign o_out.out_length  = r_olen;

    // A record-done beat is always a status-only beat that closes its input.
    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odone) |-> (!r_obvalid && r_olast))
        else $error("record-done beat carries data or is not last");

    // The produced count never passes the effective limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_produced <= MAX_OUT_CNT) && (r_produced <= r_cap || r_state == S_IDLE
        || r_state == S_END))
        else $error("produced count beyond the limit");

    // A history write happens only for a byte that fits and finds the output free.
    a_write_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (!info.at_limit && slot_free && n_ovalid))
        else $error("history write without an emitted beat");

    // While an error is pending, a beat that does not end the record is dropped.
    a_err_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && r_err != ST_OK && !i_in.record_end)
        |=> (r_state == S_IDLE && !($past(r_ovalid) && !$past(o_out.ready)) |-> !r_ovalid))
        else $error("input beat after an error produced a result");

endmodule : palmdoc_lz77_decompressor_top
`default_nettype wire

/* rtl/pdlz_hist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdlz_hist_ram
// History window: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdlz_hist_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [pdlz_pkg::HIST_AW-1:0] i_waddr,
    input  wire logic [7:0]                  i_wdata,
    input  wire logic                        i_re,
    input  wire logic [pdlz_pkg::HIST_AW-1:0] i_raddr,
    output logic      [7:0]                  o_rdata
);
    import pdlz_pkg::*;

    logic [7:0] r_mem [WINDOW_DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : pdlz_hist_ram
`default_nettype wire

/* rtl/pdlz_emit_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdlz_emit_unit
// Shared count unit: limit compare, count increment and copy source address.
// ----------------------------------------------------------------------------
module pdlz_emit_unit (
    input  wire logic [pdlz_pkg::CNT_W-1:0]  i_produced,
    input  wire logic [pdlz_pkg::CNT_W-1:0]  i_capacity,
    input  wire logic [pdlz_pkg::DIST_W-1:0] i_dist,
    output pdlz_pkg::t_emit_info             o_info
);
    import pdlz_pkg::*;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] diff;

    // The effective limit is the smaller of the register and the build maximum.
    assign limit = (i_capacity > MAX_OUT_CNT) ? MAX_OUT_CNT : i_capacity;
    assign inc   = i_produced + CNT_W'(1);
    assign diff  = i_produced - CNT_W'(i_dist);

    always_comb begin
        o_info.at_limit     = (i_produced >= limit);
        o_info.next_fail    = (inc >= limit);
        o_info.dist_bad     = (i_dist == '0) || (CNT_W'(i_dist) > i_produced);
        o_info.produced_inc = inc;
        o_info.src_addr     = diff[HIST_AW-1:0];
    end

endmodule : pdlz_emit_unit
`default_nettype wire
